[design/rolling_window_autoscale_unit_assert.svh]
// Assertion macros for the rolling window autoscale unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ROLLING_WINDOW_AUTOSCALE_UNIT_ASSERT_SVH
`define ROLLING_WINDOW_AUTOSCALE_UNIT_ASSERT_SVH

// Condition implies property in the same cycle.
`define RWAU_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rolling window autoscale same-cycle check failed");

// Condition implies property in the next cycle.
`define RWAU_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rolling window autoscale next-cycle check failed");

`endif

[design/rwa_pkg.sv]
// Shared constants and control structs for the rolling window autoscale unit.
// No dependencies.
`default_nettype none

package rwa_pkg;

    // Fixed field widths
    localparam int WL_W     = 11;   // window_length register
    localparam int DH_W     = 12;   // display_height register
    localparam int REG_W    = 12;   // widest config register
    localparam int SCALE_W  = 28;   // Q12.16 scale, saturated
    localparam int ROW_W    = 18;   // signed pixel row
    localparam int FRAC_W   = 16;   // fraction bits of the scale

    // Screen layout padding: slider strip and edges
    localparam int PAD_SLIDER = 20;
    localparam int PAD_EDGE   = 10;
    localparam int NUM_PAD    = PAD_SLIDER + 2 * PAD_EDGE;
    localparam int ROW_PAD    = PAD_SLIDER + PAD_EDGE;

    localparam logic [SCALE_W-1:0] SCALE_TOP = {SCALE_W{1'b1}};

    // Config register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DISPLAY_HEIGHT  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VERTICAL_OFFSET = 2'd2;

    // Sequencer to sample store
    typedef struct packed {
        logic wr;   // write new sample at write pointer, aim read pointer behind it
        logic rd;   // read at read pointer, step it back one slot
    } store_ctl_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done; // one-cycle pulse, quotient valid
    } div_stat_t;

endpackage

`default_nettype wire

[design/rolling_window_autoscale_unit.sv]
// Rolling window autoscale unit: sequencer, config registers and output register.
// Depends on rwa_pkg, rwa_store, rwa_div, rwa_rowmap and the assertion header.
//
// Usage:
//   s_* channel takes one sample per item (s_tdata, sample in the low bits).
//   m_* channel gives one result per item: window min/max, Q12.16 scale,
//   zero-range flag and the screen row of the newest sample.
//   cfg_we/cfg_addr/cfg_wdata write window_length (0), display_height (1)
//   and vertical_offset (2); write only while the unit is idle.
// Timing:
//   One item at a time; the next item is accepted only once the result of the
//   last one is loaded into the output register. On a zero range the divider is
//   skipped. N is the filled slots in the window, at most window_length. The
//   scan reads the N - 1 older stored samples, one per cycle, a bit-serial
//   divider forms the scale, a three-stage multiply/offset pipe forms the row.
// Reset:
//   Clears the write pointer and fill count (all slots empty) and loads
//   window_length 800, display_height 600, vertical_offset 0.
// Stall:
//   A finished result waits in the output register; the next item is
//   accepted and worked on meanwhile, and holds before its own result load.
`default_nettype none

module rolling_window_autoscale_unit #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16,
    localparam int IN_PW  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W  = 2 * SAMPLE_BITS + rwa_pkg::SCALE_W + 1 + rwa_pkg::ROW_W,
    localparam int OUT_PW = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // sample
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [IN_PW-1:0]               s_tdata,
    // window_min, window_max, scale_q16, range_zero, pixel_row, zero pad
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [OUT_PW-1:0]                   m_tdata,
    // config write port
    input  wire logic                           cfg_we,
    input  wire logic [rwa_pkg::REG_IDX_W-1:0]  cfg_addr,
    input  wire logic [rwa_pkg::REG_W-1:0]      cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LW    = (CNT_W > rwa_pkg::WL_W) ? CNT_W : rwa_pkg::WL_W;
    localparam int SW    = rwa_pkg::SCALE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_DIV,
        ST_DIVW,
        ST_ROW,
        ST_ROWW,
        ST_OUT
    } state_t;

    // Config registers
    logic [rwa_pkg::WL_W-1:0]         wl_reg;
    logic [rwa_pkg::DH_W-1:0]         dh_reg;
    logic signed [rwa_pkg::REG_W-1:0] voff_reg;

    // Sequencer and working registers
    state_t                 state_reg, state_next;
    logic [SAMPLE_BITS-1:0] y_reg, y_next;
    logic [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic [SAMPLE_BITS-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0]       iss_reg, iss_next;
    logic                   pend_reg, pend_next;
    logic [SW-1:0]          scale_reg, scale_next;
    logic                   rz_reg, rz_next;

    // Output register
    logic                          m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]        min_o_reg, max_o_reg;
    logic [SW-1:0]                 scale_o_reg;
    logic                          rz_o_reg;
    logic signed [rwa_pkg::ROW_W-1:0] row_o_reg;
    logic                          out_load;

    // Submodule links
    rwa_pkg::store_ctl_t           st_ctl;
    logic [SAMPLE_BITS-1:0]        st_rd_data;
    logic [CNT_W-1:0]              st_fill;
    logic                          div_start;
    logic [SW-1:0]                 div_dividend;
    logic [SW-1:0]                 div_quot;
    rwa_pkg::div_stat_t            div_stat;
    logic                          rm_start;
    logic signed [rwa_pkg::ROW_W-1:0] rm_row;
    logic                          rm_done;

    logic                          s_accept;
    logic [SAMPLE_BITS-1:0]        sample;
    logic [LW-1:0]                 wl_ext, len_ext;
    logic [CNT_W-1:0]              len_eff, nwin;
    logic [SAMPLE_BITS-1:0]        range_w;
    logic [rwa_pkg::DH_W-1:0]      num_w;

    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= rwa_pkg::WL_W'(800);
            dh_reg   <= rwa_pkg::DH_W'(600);
            voff_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rwa_pkg::REG_WINDOW_LENGTH:   wl_reg   <= cfg_wdata[rwa_pkg::WL_W-1:0];
                rwa_pkg::REG_DISPLAY_HEIGHT:  dh_reg   <= cfg_wdata[rwa_pkg::DH_W-1:0];
                rwa_pkg::REG_VERTICAL_OFFSET: voff_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // Effective window: zero means one, clamp to memory depth; limit to filled slots
    always_comb
    begin
        wl_ext = LW'(wl_reg);
        if (wl_reg == '0)
        begin
            len_ext = LW'(1);
        end
        else if (wl_ext > LW'(MAX_WINDOW))
        begin
            len_ext = LW'(MAX_WINDOW);
        end
        else
        begin
            len_ext = wl_ext;
        end
        len_eff = CNT_W'(len_ext);
        nwin    = (len_eff < st_fill) ? len_eff : st_fill;
    end

    // Scale numerator and range
    assign range_w      = hi_reg - lo_reg;
    assign num_w        = (dh_reg > rwa_pkg::DH_W'(rwa_pkg::NUM_PAD))
                          ? dh_reg - rwa_pkg::DH_W'(rwa_pkg::NUM_PAD) : '0;
    assign div_dividend = {num_w, {rwa_pkg::FRAC_W{1'b0}}};

    // Control toward submodules
    assign st_ctl.wr = s_accept;
    assign st_ctl.rd = (state_reg == ST_SCAN) && (iss_reg != '0);
    assign div_start = (state_reg == ST_DIV) && (range_w != '0);
    assign rm_start  = (state_reg == ST_ROW);
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // Sequencer next state and working values
    always_comb
    begin
        state_next = state_reg;
        y_next     = y_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        iss_next   = iss_reg;
        pend_next  = st_ctl.rd;
        scale_next = scale_reg;
        rz_next    = rz_reg;

        // Fold in a sample returned by the memory in the cycle after its read
        if (pend_reg)
        begin
            if (st_rd_data < lo_reg)
            begin
                lo_next = st_rd_data;
            end
            if (st_rd_data > hi_reg)
            begin
                hi_next = st_rd_data;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    y_next     = sample;
                    lo_next    = sample;
                    hi_next    = sample;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                // newest sample is already in lo/hi; scan the older ones
                iss_next   = nwin - 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (st_ctl.rd)
                begin
                    iss_next = iss_reg - 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (range_w == '0)
                begin
                    scale_next = rwa_pkg::SCALE_TOP;
                    rz_next    = 1'b1;
                    state_next = ST_ROW;
                end
                else
                begin
                    rz_next    = 1'b0;
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    scale_next = div_quot;
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                state_next = ST_ROWW;
            end
            ST_ROWW:
            begin
                if (rm_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            iss_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            iss_reg   <= iss_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        y_reg     <= y_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        scale_reg <= scale_next;
        rz_reg    <= rz_next;
        if (out_load)
        begin
            min_o_reg   <= lo_reg;
            max_o_reg   <= hi_reg;
            scale_o_reg <= scale_reg;
            rz_o_reg    <= rz_reg;
            row_o_reg   <= rm_row;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_PW - OUT_W){1'b0}}, row_o_reg, rz_o_reg, scale_o_reg,
                       max_o_reg, min_o_reg};

    rwa_store #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (st_ctl),
        .wr_data (sample),
        .rd_data (st_rd_data),
        .fill    (st_fill)
    );

    rwa_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (range_w),
        .quot     (div_quot),
        .stat     (div_stat)
    );

    rwa_rowmap #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rowmap (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rm_start),
        .diff  (y_reg - lo_reg),
        .scale (scale_reg),
        .voff  (voff_reg),
        .dh    (dh_reg),
        .row   (rm_row),
        .done  (rm_done)
    );

    // Checks
`include "rolling_window_autoscale_unit_assert.svh"

    `RWAU_ASSERT_NOW(a_min_le_max, m_tvalid_reg, min_o_reg <= max_o_reg)
    `RWAU_ASSERT_NOW(a_rz_matches, m_tvalid_reg, rz_o_reg == (min_o_reg == max_o_reg))
    `RWAU_ASSERT_NOW(a_rz_saturates, m_tvalid_reg && rz_o_reg, scale_o_reg == rwa_pkg::SCALE_TOP)
    `RWAU_ASSERT_NEXT(a_one_at_a_time, s_accept, !s_tready)

endmodule

`default_nettype wire

[design/rwa_store.sv]
// Circular sample memory with write pointer, backward read pointer and fill count.
// Depends on rwa_pkg.
`default_nettype none

module rwa_store #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16,
    localparam int AW    = $clog2(MAX_WINDOW),
    localparam int CNT_W = $clog2(MAX_WINDOW + 1)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rwa_pkg::store_ctl_t    ctl,
    input  wire logic [SAMPLE_BITS-1:0] wr_data,
    output logic [SAMPLE_BITS-1:0]      rd_data,
    output logic [CNT_W-1:0]            fill
);

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [AW-1:0]          rp_reg, rp_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;

    // Pointer and fill count updates; slots below the fill count are the valid ones
    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        fill_next = fill_reg;
        if (ctl.wr)
        begin
            wp_next = (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
            rp_next = (wp_reg == '0) ? AW'(MAX_WINDOW - 1) : wp_reg - 1'b1;
            if (fill_reg != CNT_W'(MAX_WINDOW))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        else if (ctl.rd)
        begin
            rp_next = (rp_reg == '0) ? AW'(MAX_WINDOW - 1) : rp_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    // Synchronous memory, one write and one read port, registered read.
    // Sequencer never reads the slot being written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wp_reg] <= wr_data;
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[rp_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

endmodule

`default_nettype wire

[design/rwa_div.sv]
// Restoring divider, one quotient bit per cycle, for the Q12.16 scale.
// Depends on rwa_pkg.
`default_nettype none

module rwa_div #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rwa_pkg::SCALE_W-1:0]   dividend,
    input  wire logic [SAMPLE_BITS-1:0]        divisor,
    output logic [rwa_pkg::SCALE_W-1:0]        quot,
    output rwa_pkg::div_stat_t                 stat
);

    localparam int QW = rwa_pkg::SCALE_W;
    localparam int CW = $clog2(QW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [QW-1:0]     q_reg;
    logic [SAMPLE_BITS:0] rem_reg;
    logic [SAMPLE_BITS-1:0] dv_reg;
    logic [SAMPLE_BITS:0] trial;
    logic              fits;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial = {rem_reg[SAMPLE_BITS-1:0], q_reg[QW-1]};
        fits  = (trial >= {1'b0, dv_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dv_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[QW-2:0], fits};
            rem_reg <= fits ? (trial - {1'b0, dv_reg}) : trial;
        end
    end

    assign quot      = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

[design/rwa_rowmap.sv]
// Three-stage row mapper: multiply by scale, add offset, truncate and flip to a row.
// Depends on rwa_pkg.
`default_nettype none

module rwa_rowmap #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [SAMPLE_BITS-1:0]        diff,
    input  wire logic [rwa_pkg::SCALE_W-1:0]   scale,
    input  wire logic signed [rwa_pkg::REG_W-1:0] voff,
    input  wire logic [rwa_pkg::DH_W-1:0]      dh,
    output logic signed [rwa_pkg::ROW_W-1:0]   row,
    output logic                               done
);

    localparam int PW = SAMPLE_BITS + rwa_pkg::SCALE_W;
    localparam int TW = PW + 2;

    logic v1_reg, v2_reg, done_reg;
    logic [PW-1:0]                   prod_reg;
    logic signed [rwa_pkg::REG_W-1:0] voff1_reg;
    logic [rwa_pkg::DH_W-1:0]        dh1_reg, dh2_reg;
    logic signed [TW-1:0]            t_reg, t_next;
    logic signed [TW-1:0]            prod_ext, off_sh;
    logic [TW-1:0]                   tq;
    logic [rwa_pkg::ROW_W-1:0]       q_lo;
    logic [rwa_pkg::ROW_W-1:0]       row_reg, row_next;

    // Stage 2: exact scaled height plus offset in pixels
    always_comb
    begin
        prod_ext = $signed(TW'(prod_reg));
        off_sh   = TW'(voff1_reg) <<< rwa_pkg::FRAC_W;
        t_next   = prod_ext + off_sh;
    end

    // Stage 3: truncate toward zero, then row = height - padding - height_px
    always_comb
    begin
        tq       = t_reg + (t_reg[TW-1] ? TW'({rwa_pkg::FRAC_W{1'b1}}) : '0);
        q_lo     = tq[rwa_pkg::FRAC_W +: rwa_pkg::ROW_W];
        row_next = rwa_pkg::ROW_W'(dh2_reg) - rwa_pkg::ROW_W'(rwa_pkg::ROW_PAD) - q_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg  <= diff * scale;
            voff1_reg <= voff;
            dh1_reg   <= dh;
        end
        if (v1_reg)
        begin
            t_reg   <= t_next;
            dh2_reg <= dh1_reg;
        end
        if (v2_reg)
        begin
            row_reg <= row_next;
        end
    end

    assign row  = $signed(row_reg);
    assign done = done_reg;

endmodule

`default_nettype wire
